/* hw/rtl/jts_pkg.sv */
// jts_pkg: shared types and character constants of the json token scanner
// scanner state codes, token kinds and the queue entry that joins front and back
// no dependencies
package jts_pkg;

  typedef enum logic [5:0] {
    ST_START  = 6'd0,
    ST_T1     = 6'd1,
    ST_T2     = 6'd2,
    ST_T3     = 6'd3,
    ST_TRUE   = 6'd4,
    ST_F1     = 6'd5,
    ST_F2     = 6'd6,
    ST_F3     = 6'd7,
    ST_F4     = 6'd8,
    ST_FALSE  = 6'd9,
    ST_N1     = 6'd10,
    ST_N2     = 6'd11,
    ST_N3     = 6'd12,
    ST_NULL   = 6'd13,
    ST_STR    = 6'd14,
    ST_ESC    = 6'd15,
    ST_MINUS  = 6'd16,
    ST_ZERO   = 6'd17,
    ST_INT    = 6'd18,
    ST_DOT    = 6'd19,
    ST_FRAC   = 6'd20,
    ST_EXP    = 6'd21,
    ST_EXPSGN = 6'd22,
    ST_EXPDIG = 6'd23
  } scan_state_e;

  typedef enum logic [3:0] {
    TK_ERROR  = 4'd0,
    TK_TRUE   = 4'd1,
    TK_FALSE  = 4'd2,
    TK_NULL   = 4'd3,
    TK_LBRACE = 4'd4,
    TK_RBRACE = 4'd5,
    TK_LBRACK = 4'd6,
    TK_RBRACK = 4'd7,
    TK_COMMA  = 4'd8,
    TK_COLON  = 4'd9,
    TK_STRING = 4'd10,
    TK_INT    = 4'd11,
    TK_REAL   = 4'd12,
    TK_END    = 4'd13
  } tok_kind_e;

  // one or two tokens caused by one byte
  typedef struct packed {
    logic      two;
    tok_kind_e first;
    tok_kind_e second;
  } tok_pair_t;

  typedef struct packed {
    logic      valid;
    tok_pair_t pair;
  } tok_push_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  localparam logic [7:0] CharNul       = 8'h00;
  localparam logic [7:0] CharNewline   = 8'h0a;
  localparam logic [7:0] CharSpace     = 8'h20;
  localparam logic [7:0] CharQuote     = 8'h22;
  localparam logic [7:0] CharPlus      = 8'h2b;
  localparam logic [7:0] CharComma     = 8'h2c;
  localparam logic [7:0] CharMinus     = 8'h2d;
  localparam logic [7:0] CharDot       = 8'h2e;
  localparam logic [7:0] CharZero      = 8'h30;
  localparam logic [7:0] CharOne       = 8'h31;
  localparam logic [7:0] CharNine      = 8'h39;
  localparam logic [7:0] CharColon     = 8'h3a;
  localparam logic [7:0] CharUpE       = 8'h45;
  localparam logic [7:0] CharLBrack    = 8'h5b;
  localparam logic [7:0] CharBackslash = 8'h5c;
  localparam logic [7:0] CharRBrack    = 8'h5d;
  localparam logic [7:0] CharLowA      = 8'h61;
  localparam logic [7:0] CharLowE      = 8'h65;
  localparam logic [7:0] CharLowF      = 8'h66;
  localparam logic [7:0] CharLowL      = 8'h6c;
  localparam logic [7:0] CharLowN      = 8'h6e;
  localparam logic [7:0] CharLowR      = 8'h72;
  localparam logic [7:0] CharLowS      = 8'h73;
  localparam logic [7:0] CharLowT      = 8'h74;
  localparam logic [7:0] CharLowU      = 8'h75;
  localparam logic [7:0] CharLBrace    = 8'h7b;
  localparam logic [7:0] CharRBrace    = 8'h7d;

endpackage

/* hw/rtl/jts_front.sv */
// jts_front: lexer automaton, takes one byte per transaction and classifies it
// pushes the one or two tokens a byte causes into the token queue
// depends on jts_pkg
module jts_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [7:0]         text_byte_i,
  input  jts_pkg::q_status_t q_status_i,
  output logic               in_stall_o,
  output jts_pkg::tok_push_t push_o
);
  import jts_pkg::*;

  scan_state_e state_q, state_d, nxt, adv_state;
  logic        accept, emit, adv_ok, is_sep, blank, digit, expo, done_ok;
  tok_kind_e   sep_kind, done_kind;
  tok_pair_t   pair;
  logic [7:0]  kw_char;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;

  assign blank = (text_byte_i == CharSpace) || (text_byte_i == CharNewline);
  assign digit = text_byte_i inside {[CharZero:CharNine]};
  assign expo  = (text_byte_i == CharLowE) || (text_byte_i == CharUpE);

  always_comb begin
    is_sep   = 1'b1;
    sep_kind = TK_ERROR;
    case (text_byte_i)
      CharLBrace: sep_kind = TK_LBRACE;
      CharRBrace: sep_kind = TK_RBRACE;
      CharLBrack: sep_kind = TK_LBRACK;
      CharRBrack: sep_kind = TK_RBRACK;
      CharComma:  sep_kind = TK_COMMA;
      CharColon:  sep_kind = TK_COLON;
      default:    is_sep   = 1'b0;
    endcase
  end

  always_comb begin
    done_kind = TK_ERROR;
    case (state_q)
      ST_TRUE:             done_kind = TK_TRUE;
      ST_FALSE:            done_kind = TK_FALSE;
      ST_NULL:             done_kind = TK_NULL;
      ST_ZERO, ST_INT:     done_kind = TK_INT;
      ST_FRAC, ST_EXPDIG:  done_kind = TK_REAL;
      default:             done_kind = TK_ERROR;
    endcase
  end
  assign done_ok = (done_kind != TK_ERROR);

  // expected next letter inside a keyword
  always_comb begin
    case (state_q)
      ST_T1:   kw_char = CharLowR;
      ST_T2:   kw_char = CharLowU;
      ST_T3:   kw_char = CharLowE;
      ST_F1:   kw_char = CharLowA;
      ST_F2:   kw_char = CharLowL;
      ST_F3:   kw_char = CharLowS;
      ST_F4:   kw_char = CharLowE;
      ST_N1:   kw_char = CharLowU;
      ST_N2:   kw_char = CharLowL;
      ST_N3:   kw_char = CharLowL;
      default: kw_char = CharNul;
    endcase
  end

  // continuation of keywords and numbers
  always_comb begin
    adv_ok    = 1'b0;
    adv_state = ST_START;
    case (state_q)
      ST_MINUS: begin
        if (text_byte_i == CharZero) begin
          adv_ok    = 1'b1;
          adv_state = ST_ZERO;
        end else if (digit) begin
          adv_ok    = 1'b1;
          adv_state = ST_INT;
        end
      end
      ST_ZERO: begin
        if (text_byte_i == CharDot) begin
          adv_ok    = 1'b1;
          adv_state = ST_DOT;
        end else if (expo) begin
          adv_ok    = 1'b1;
          adv_state = ST_EXP;
        end
      end
      ST_INT: begin
        if (digit) begin
          adv_ok    = 1'b1;
          adv_state = ST_INT;
        end else if (text_byte_i == CharDot) begin
          adv_ok    = 1'b1;
          adv_state = ST_DOT;
        end else if (expo) begin
          adv_ok    = 1'b1;
          adv_state = ST_EXP;
        end
      end
      ST_DOT: begin
        if (digit) begin
          adv_ok    = 1'b1;
          adv_state = ST_FRAC;
        end
      end
      ST_FRAC: begin
        if (digit) begin
          adv_ok    = 1'b1;
          adv_state = ST_FRAC;
        end else if (expo) begin
          adv_ok    = 1'b1;
          adv_state = ST_EXP;
        end
      end
      ST_EXP: begin
        if ((text_byte_i == CharPlus) || (text_byte_i == CharMinus)) begin
          adv_ok    = 1'b1;
          adv_state = ST_EXPSGN;
        end else if (digit) begin
          adv_ok    = 1'b1;
          adv_state = ST_EXPDIG;
        end
      end
      ST_EXPSGN, ST_EXPDIG: begin
        if (digit) begin
          adv_ok    = 1'b1;
          adv_state = ST_EXPDIG;
        end
      end
      default: begin
        if ((state_q < ST_STR) && (kw_char != CharNul) && (kw_char == text_byte_i)) begin
          adv_ok    = 1'b1;
          adv_state = scan_state_e'(state_q + 6'd1);
        end
      end
    endcase
  end

  always_comb begin
    nxt         = ST_START;
    emit        = 1'b0;
    pair.two    = 1'b0;
    pair.first  = TK_ERROR;
    pair.second = TK_END;
    if (text_byte_i == CharNul) begin
      emit = 1'b1;
      if (state_q != ST_START) begin
        pair.two    = 1'b1;
        pair.first  = done_ok ? done_kind : TK_ERROR;
        pair.second = TK_END;
      end else begin
        pair.first = TK_END;
      end
    end else if (state_q == ST_START) begin
      if (is_sep) begin
        emit       = 1'b1;
        pair.first = sep_kind;
      end else if (blank) begin
        nxt = ST_START;
      end else if (text_byte_i == CharLowT) begin
        nxt = ST_T1;
      end else if (text_byte_i == CharLowF) begin
        nxt = ST_F1;
      end else if (text_byte_i == CharLowN) begin
        nxt = ST_N1;
      end else if (text_byte_i == CharQuote) begin
        nxt = ST_STR;
      end else if (text_byte_i == CharMinus) begin
        nxt = ST_MINUS;
      end else if (text_byte_i == CharZero) begin
        nxt = ST_ZERO;
      end else if (text_byte_i inside {[CharOne:CharNine]}) begin
        nxt = ST_INT;
      end else begin
        emit = 1'b1;
      end
    end else if (state_q == ST_STR) begin
      if (text_byte_i == CharBackslash) begin
        nxt = ST_ESC;
      end else if (text_byte_i == CharQuote) begin
        emit       = 1'b1;
        pair.first = TK_STRING;
      end else begin
        nxt = ST_STR;
      end
    end else if (state_q == ST_ESC) begin
      nxt = ST_STR;
    end else if (done_ok && (is_sep || blank)) begin
      emit        = 1'b1;
      pair.first  = done_kind;
      pair.two    = is_sep;
      pair.second = sep_kind;
    end else if (adv_ok) begin
      nxt = adv_state;
    end else begin
      emit = 1'b1;
    end
  end

  assign state_d     = accept ? nxt : state_q;
  assign push_o.valid = accept && emit;
  assign push_o.pair  = pair;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_START;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hw/rtl/jts_queue.sv */
// jts_queue: short token queue between the lexer front and the output back
// register queue of token pairs with read and write pointers
// depends on jts_pkg
module jts_queue #(
  parameter int Depth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jts_pkg::tok_push_t push_i,
  input  logic               pop_i,
  output jts_pkg::tok_pair_t head_o,
  output jts_pkg::q_status_t status_o
);
  import jts_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  tok_pair_t           mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CntW'(Depth));
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i.valid) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({push_i.valid, pop_i})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.pair;
    end
  end

endmodule

/* hw/rtl/jts_back.sv */
// jts_back: output stage, sends queued tokens one transaction per cycle while out_stall_i is low
// splits a token pair into two transactions and marks the last token of each byte
// depends on jts_pkg
module jts_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jts_pkg::tok_pair_t head_i,
  input  jts_pkg::q_status_t q_status_i,
  input  logic               out_stall_i,
  output logic               pop_o,
  output logic               out_valid_o,
  output logic [3:0]         token_kind_o,
  output logic               last_of_run_o
);
  import jts_pkg::*;

  logic      out_valid_q, out_valid_d, half_q, half_d, last_q, last_d, slot_free;
  tok_kind_e kind_q, kind_d;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    pop_o       = 1'b0;
    half_d      = half_q;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    last_d      = last_q;
    if (slot_free) begin
      if (!q_status_i.empty) begin
        out_valid_d = 1'b1;
        if (half_q) begin
          kind_d = head_i.second;
          last_d = 1'b1;
          pop_o  = 1'b1;
          half_d = 1'b0;
        end else begin
          kind_d = head_i.first;
          last_d = !head_i.two;
          pop_o  = !head_i.two;
          half_d = head_i.two;
        end
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      half_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      half_q      <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    last_q <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign token_kind_o  = kind_q;
  assign last_of_run_o = last_q;

endmodule

/* hw/rtl/json_token_scanner.sv */
// json_token_scanner: top level of the byte-serial json lexer
// channel   | direction | handshake                | payload
// in        | input     | in_valid_i / in_stall_o  | text_byte_i
// out       | output    | out_valid_o / out_stall_i| token_kind_o, last_of_run_o
// one byte per cycle enters the automaton while in_stall_o is low; its tokens go to a queue of QueueDepth entries
// the output stage sends one token per cycle while out_stall_i is low, so a byte with two tokens uses two transactions
// first token of a byte passes through the queue and then the output register, if no earlier token waits
// in_stall_o is high only while the queue is full
// reset returns the automaton to start and empties queue and output register
// depends on jts_pkg, jts_front, jts_queue, jts_back
module json_token_scanner #(
  parameter int QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] token_kind_o,
  output logic       last_of_run_o
);
  import jts_pkg::*;

  tok_push_t push;
  tok_pair_t head;
  q_status_t q_status;
  logic      pop;

  jts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .text_byte_i (text_byte_i),
    .q_status_i  (q_status),
    .in_stall_o  (in_stall_o),
    .push_o      (push)
  );

  jts_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  jts_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .q_status_i    (q_status),
    .out_stall_i   (out_stall_i),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .token_kind_o  (token_kind_o),
    .last_of_run_o (last_of_run_o)
  );

  // end of input always queues an end token as the last of its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (text_byte_i == CharNul)) |->
      (push.valid && (push.pair.two ? (push.pair.second == TK_END)
                                    : (push.pair.first == TK_END))))
    else $error("end of input did not queue an end token");

  // the second token of a pair follows right after the first is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_of_run_o) |=> (out_valid_o && last_of_run_o))
    else $error("second token of a pair did not follow");

  // an end token is never followed by another token of the same byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_of_run_o) |-> (token_kind_o != TK_END))
    else $error("end token not last of its run");

  // the queue is never popped while empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("token queue popped while empty");

endmodule
